// ===== design/teh_pkg.sv =====
// Package for the timer event min-heap: sizes, codes, request/result and
// entry types, controller state type. No dependencies.
package teh_pkg;

	localparam int HEAP_DEPTH  = 32;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
	localparam int ADDR_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int NPOP_W      = $clog2(MAX_RESULTS + 1);

	localparam logic ACT_POST = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_POSTED = 2'd0,
		ST_FULL   = 2'd1,
		ST_FIRED  = 2'd2,
		ST_NONE   = 2'd3
	} status_t;

	typedef struct packed {
		logic        action;
		logic [31:0] time_value;
		logic [7:0]  handler_id;
		logic [15:0] target_tag;
		logic [31:0] word_param;
		logic [15:0] ref_param;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  fired_handler;
		logic [15:0] fired_target;
		logic [31:0] fired_word;
		logic [15:0] fired_ref;
		logic        last;
	} rsp_t;

	// one heap slot as stored in the entry RAM
	typedef struct packed {
		logic [31:0] due;
		logic [7:0]  handler;
		logic [15:0] target;
		logic [31:0] word;
		logic [15:0] ref_tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to entry RAM
	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] ra_addr;
		logic [ADDR_W-1:0] rb_addr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
	} ram_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REJ,
		S_INS_CMP,
		S_INS_PUT,
		S_POP_CHK,
		S_SD_CMP,
		S_POP_RD
	} heap_state_t;

endpackage

// ===== design/teh_if.sv =====
// Request and result channel interfaces (valid/ready plus payload).
// Depends on teh_pkg.
interface teh_req_if;
	logic          valid;
	logic          ready;
	teh_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface teh_rsp_if;
	logic          valid;
	logic          ready;
	teh_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/timer_event_min_heap_unit.sv =====
// Timer event min-heap top level: request/result channels, sequencer,
// entry RAM and output register. Depends on teh_pkg, teh_if, teh_ram,
// teh_heap_ctrl.
//  - req (sink): a post request (action 0) inserts an event due at
//    time_value; a tick request (action 1) fires every event whose due time
//    is strictly below time_value, earliest first, up to MAX_RESULTS.
//  - rsp (source): one result per post (accepted or full), one result per
//    fired event, or a single nothing-due result; last marks the final one.
//  - One request is worked on at a time; req.ready is high only when the
//    sequencer is idle. The output register lets the next request in while
//    the final result still waits on rsp.
//  - Post: the result goes to rsp once the new event has climbed past every
//    strictly later parent (up to log2 of HEAP_DEPTH levels).
//  - Tick: with nothing due, the result follows the root check. Each fired
//    event takes a root check, one sift-down step per level (1 to log2 of
//    HEAP_DEPTH) and a reread of the root, all through the one entry RAM
//    with its one write port and two read ports.
//  - Reset clears the entry count and the sequencer; RAM content is not
//    cleared, and data read from slots above the live count is never used.
//  - A stalled rsp holds the sequencer in place; no result is dropped.
module timer_event_min_heap_unit (
	input  logic      clk,
	input  logic      arst_n,
	teh_req_if.sink   req,
	teh_rsp_if.source rsp
);
	import teh_pkg::*;

	logic     res_valid;
	logic     res_ready;
	rsp_t     res_data;
	ram_cmd_t ram;
	entry_t   ra_data, rb_data;

	logic     out_v_q;
	rsp_t     out_q;

	teh_heap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (res_ready),
		.ram       (ram),
		.ra_data   (ra_data),
		.rb_data   (rb_data)
	);

	teh_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (HEAP_DEPTH)
	) u_ram (
		.clk     (clk),
		.re      (ram.re),
		.ra_addr (ram.ra_addr),
		.rb_addr (ram.rb_addr),
		.ra_data (ra_data),
		.rb_data (rb_data),
		.we      (ram.we),
		.waddr   (ram.waddr),
		.wdata   (ram.wdata)
	);

	// output register: takes a new result when empty or being drained
	assign res_ready = !out_v_q || rsp.ready;
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res_data;
		end
	end

endmodule

// ===== design/teh_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data
// (read-old on a same-address write). No dependencies.
module teh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              re,
	input  logic [ADDR_W-1:0] ra_addr,
	input  logic [ADDR_W-1:0] rb_addr,
	output logic [WIDTH-1:0]  ra_data,
	output logic [WIDTH-1:0]  rb_data,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			ra_data <= mem[ra_addr];
			rb_data <= mem[rb_addr];
		end
	end

endmodule

// ===== design/teh_heap_ctrl.sv =====
// Heap sequencer: sift-up on post, pop and sift-down on tick, one level
// per cycle against the entry RAM. Depends on teh_pkg, teh_if.
module teh_heap_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	teh_req_if.sink           req,
	output logic              res_valid,
	output teh_pkg::rsp_t     res_data,
	input  logic              res_ready,
	output teh_pkg::ram_cmd_t ram,
	input  teh_pkg::entry_t   ra_data,
	input  teh_pkg::entry_t   rb_data
);
	import teh_pkg::*;

	heap_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic [NPOP_W-1:0] n_q, n_d;
	logic              pend_v_q, pend_v_d;
	entry_t            pend_q, pend_d;
	entry_t            hold_q, hold_d;
	logic [31:0]       now_q, now_d;

	logic [CNT_W:0]    lc, rc, pick_idx, pos_acc;
	logic              lv, rv, pick_l, pick_r, due;
	logic [31:0]       best_t;
	logic [CNT_W-1:0]  par;
	entry_t            req_entry;

	function automatic logic [ADDR_W-1:0] idx2addr(input logic [CNT_W:0] x);
		logic [CNT_W:0] d;
		d = x - 1'b1;
		return d[ADDR_W-1:0];
	endfunction

	function automatic rsp_t mk_res(input status_t st, input entry_t e, input logic lst);
		rsp_t r;
		r.status        = st;
		r.fired_handler = e.handler;
		r.fired_target  = e.target;
		r.fired_word    = e.word;
		r.fired_ref     = e.ref_tag;
		r.last          = lst;
		return r;
	endfunction

	always_comb begin
		req_entry.due     = req.data.time_value;
		req_entry.handler = req.data.handler_id;
		req_entry.target  = req.data.target_tag;
		req_entry.word    = req.data.word_param;
		req_entry.ref_tag = req.data.ref_param;
	end

	// sift-down child choice: left only if strictly smaller, right only if
	// strictly smaller than the current best
	assign lc       = {pos_q, 1'b0};
	assign rc       = {pos_q, 1'b1};
	assign lv       = lc <= {1'b0, cnt_q};
	assign rv       = rc <= {1'b0, cnt_q};
	assign pick_l   = lv && (ra_data.due < hold_q.due);
	assign best_t   = pick_l ? ra_data.due : hold_q.due;
	assign pick_r   = rv && (rb_data.due < best_t);
	assign pick_idx = pick_r ? rc : lc;
	assign par      = pos_q >> 1;
	assign pos_acc  = {1'b0, cnt_q} + 1'b1;
	assign due      = (cnt_q != '0) && (ra_data.due < now_q)
		&& (n_q < NPOP_W'(MAX_RESULTS));

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		n_d       = n_q;
		pend_v_d  = pend_v_q;
		pend_d    = pend_q;
		hold_d    = hold_q;
		now_d     = now_q;
		ram       = '0;
		res_valid = 1'b0;
		res_data  = mk_res(ST_NONE, '0, 1'b1);
		req.ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.data.action == ACT_POST) begin
						hold_d = req_entry;
						if (cnt_q >= CNT_W'(HEAP_DEPTH)) begin
							state_d = S_REJ;
						end else begin
							cnt_d = pos_acc[CNT_W-1:0];
							pos_d = pos_acc[CNT_W-1:0];
							if (cnt_q == '0) begin
								state_d = S_INS_PUT;
							end else begin
								ram.re      = 1'b1;
								ram.ra_addr = idx2addr(pos_acc >> 1);
								state_d     = S_INS_CMP;
							end
						end
					end else begin
						now_d       = req.data.time_value;
						n_d         = '0;
						pend_v_d    = 1'b0;
						ram.re      = 1'b1;
						ram.ra_addr = '0;
						ram.rb_addr = idx2addr({1'b0, cnt_q});
						state_d     = S_POP_CHK;
					end
				end
			end
			S_REJ: begin
				res_valid = 1'b1;
				res_data  = mk_res(ST_FULL, '0, 1'b1);
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			S_INS_CMP: begin
				if (ra_data.due > hold_q.due) begin
					ram.we    = 1'b1;
					ram.waddr = idx2addr({1'b0, pos_q});
					ram.wdata = ra_data;
					pos_d     = par;
					if (par == CNT_W'(1)) begin
						state_d = S_INS_PUT;
					end else begin
						ram.re      = 1'b1;
						ram.ra_addr = idx2addr({1'b0, par >> 1});
					end
				end else begin
					res_valid = 1'b1;
					res_data  = mk_res(ST_POSTED, '0, 1'b1);
					if (res_ready) begin
						ram.we    = 1'b1;
						ram.waddr = idx2addr({1'b0, pos_q});
						ram.wdata = hold_q;
						state_d   = S_IDLE;
					end
				end
			end
			S_INS_PUT: begin
				res_valid = 1'b1;
				res_data  = mk_res(ST_POSTED, '0, 1'b1);
				if (res_ready) begin
					ram.we    = 1'b1;
					ram.waddr = '0;
					ram.wdata = hold_q;
					state_d   = S_IDLE;
				end
			end
			S_POP_CHK: begin
				if (due) begin
					// previous pop is not the last one
					res_valid = pend_v_q;
					res_data  = mk_res(ST_FIRED, pend_q, 1'b0);
					if (!pend_v_q || res_ready) begin
						pend_d      = ra_data;
						pend_v_d    = 1'b1;
						n_d         = n_q + 1'b1;
						cnt_d       = cnt_q - 1'b1;
						hold_d      = rb_data;
						pos_d       = CNT_W'(1);
						ram.re      = 1'b1;
						ram.ra_addr = idx2addr((CNT_W + 1)'(2));
						ram.rb_addr = idx2addr((CNT_W + 1)'(3));
						state_d     = S_SD_CMP;
					end
				end else begin
					res_valid = 1'b1;
					res_data  = pend_v_q ? mk_res(ST_FIRED, pend_q, 1'b1)
						: mk_res(ST_NONE, '0, 1'b1);
					if (res_ready) begin
						pend_v_d = 1'b0;
						state_d  = S_IDLE;
					end
				end
			end
			S_SD_CMP: begin
				ram.we    = 1'b1;
				ram.waddr = idx2addr({1'b0, pos_q});
				if (pick_l || pick_r) begin
					ram.wdata   = pick_r ? rb_data : ra_data;
					pos_d       = pick_idx[CNT_W-1:0];
					ram.re      = 1'b1;
					ram.ra_addr = idx2addr({pick_idx[CNT_W-1:0], 1'b0});
					ram.rb_addr = idx2addr({pick_idx[CNT_W-1:0], 1'b1});
				end else begin
					ram.wdata = hold_q;
					state_d   = S_POP_RD;
				end
			end
			S_POP_RD: begin
				ram.re      = 1'b1;
				ram.ra_addr = '0;
				ram.rb_addr = idx2addr({1'b0, cnt_q});
				state_d     = S_POP_CHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			n_q      <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			n_q      <= n_d;
			pend_v_q <= pend_v_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		pend_q <= pend_d;
		hold_q <= hold_d;
		now_q  <= now_d;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HEAP_DEPTH))
		else $error("entry count above heap depth");

	a_post_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.data.action == ACT_POST
			&& cnt_q < CNT_W'(HEAP_DEPTH)) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("accepted post did not add an entry");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && res_data.last) |=> state_q == S_IDLE)
		else $error("final result not followed by idle");

	a_fire_src: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.status == ST_FIRED) |-> state_q == S_POP_CHK)
		else $error("fired result outside pop check");

	a_pop_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NPOP_W'(MAX_RESULTS))
		else $error("pop count above limit");
`endif

endmodule

// ===== tb/timer_event_min_heap_unit_tb.sv =====
// Self-checking testbench for timer_event_min_heap_unit: a directed table, then
// random post/tick traffic under sender gaps and result stalls.
// Depends on teh_pkg, teh_if and the RTL under design/.
module timer_event_min_heap_unit_tb;
	import teh_pkg::*;

	// Clock, reset, channels

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	teh_req_if req_ch ();
	teh_rsp_if rsp_ch ();

	timer_event_min_heap_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Canned results for rows whose outcome is obvious
	localparam rsp_t RSP_POSTED = '{ST_POSTED, 8'h00, 16'h0000, 32'h0, 16'h0000, 1'b1};
	localparam rsp_t RSP_NONE   = '{ST_NONE, 8'h00, 16'h0000, 32'h0, 16'h0000, 1'b1};
	localparam rsp_t RSP_ANY    = '0;

	// Directed stimulus. has_exp rows carry their result inline; the others
	// go through the heap predictor. Rows from SCRIPT_HEAD on run after the
	// random part, once the heap is drained: a post at the top of the time
	// range can never fire, so it would otherwise sit in a slot for good.
	typedef struct {
		req_t rq;
		bit   has_exp;
		rsp_t exp;
	} script_row_t;

	localparam int SCRIPT_ROWS = 20;
	localparam int SCRIPT_HEAD = 17;

	script_row_t script [SCRIPT_ROWS] = '{
		// empty heap: ticks at both ends of time fire nothing
		'{'{ACT_TICK, 32'h0000_0000, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, RSP_NONE},
		'{'{ACT_TICK, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, RSP_NONE},
		// due at time zero with all-ones payload
		'{'{ACT_POST, 32'h0000_0000, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, RSP_POSTED},
		// strict compare: tick at 0 does not fire an event due at 0
		'{'{ACT_TICK, 32'h0000_0000, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, RSP_NONE},
		// two events with equal due time, then one that climbs past them
		'{'{ACT_POST, 32'h0000_0005, 8'h11, 16'h1111, 32'h1111_1111, 16'h1111}, 1'b1, RSP_POSTED},
		'{'{ACT_POST, 32'h0000_0005, 8'h22, 16'h2222, 32'h2222_2222, 16'h2222}, 1'b1, RSP_POSTED},
		'{'{ACT_POST, 32'h0000_0003, 8'hA5, 16'h5A5A, 32'hA5A5_A5A5, 16'h5A5A}, 1'b1, RSP_POSTED},
		'{'{ACT_POST, 32'h0000_0007, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, RSP_POSTED},
		// fire one, then boundary, then the tie pair, then the rest
		'{'{ACT_TICK, 32'h0000_0001, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b0, RSP_ANY},
		'{'{ACT_TICK, 32'h0000_0005, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b0, RSP_ANY},
		'{'{ACT_TICK, 32'h0000_0006, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b0, RSP_ANY},
		'{'{ACT_TICK, 32'h0000_0008, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b0, RSP_ANY},
		'{'{ACT_TICK, 32'h0000_0008, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, RSP_NONE},
		// unsigned compare across bit 31, no wraparound
		'{'{ACT_POST, 32'h8000_0000, 8'h5A, 16'hA5A5, 32'h5A5A_5A5A, 16'hA5A5}, 1'b1, RSP_POSTED},
		'{'{ACT_POST, 32'h7FFF_FFFF, 8'hC3, 16'h3C3C, 32'hC3C3_C3C3, 16'h3C3C}, 1'b1, RSP_POSTED},
		'{'{ACT_TICK, 32'h8000_0000, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b0, RSP_ANY},
		'{'{ACT_TICK, 32'h8000_0001, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b0, RSP_ANY},
		// tail rows: latest possible due time never fires
		'{'{ACT_POST, 32'hFFFF_FFFF, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, RSP_POSTED},
		'{'{ACT_TICK, 32'hFFFF_FFFF, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, RSP_NONE},
		'{'{ACT_TICK, 32'h0000_0000, 8'h00, 16'h0000, 32'h0000_0000, 16'h0000}, 1'b1, RSP_NONE}
	};

	// Heap predictor state: one-based slots, live count

	entry_t      heap_slot [1:HEAP_DEPTH];
	int unsigned heap_fill = 0;

	rsp_t awaited [$];      // results still owed by the DUT, oldest first

	int errors     = 0;
	int req_count  = 0;
	int rsp_count  = 0;
	int n_fired    = 0;
	int n_rejected = 0;
	int n_empty    = 0;
	int n_max_pop  = 0;

	int gap_pct   = 0;      // sender idle chance per cycle
	int stall_pct = 0;      // receiver stall chance per cycle

	// Apply one request to the predicted heap and return the results it owes.
	// Post: sift up past strictly later parents. Tick: pop while root is
	// strictly earlier, at most MAX_RESULTS, sifting the old tail down from
	// the root (left child wins ties).
	function automatic void heap_apply(input req_t rq, output rsp_t res [$]);
		entry_t      ent;
		entry_t      tail;
		rsp_t        one;
		int unsigned pos;
		int unsigned kid;
		logic [31:0] key;
		bit          done;

		res = {};
		one = '0;
		one.last = 1'b1;
		if (rq.action == ACT_POST) begin
			if (heap_fill >= HEAP_DEPTH) begin
				one.status = ST_FULL;
				n_rejected++;
			end else begin
				ent = '{due: rq.time_value, handler: rq.handler_id, target: rq.target_tag,
					word: rq.word_param, ref_tag: rq.ref_param};
				heap_fill++;
				pos = heap_fill;
				while (pos > 1 && heap_slot[pos / 2].due > ent.due) begin
					heap_slot[pos] = heap_slot[pos / 2];
					pos = pos / 2;
				end
				heap_slot[pos] = ent;
				one.status = ST_POSTED;
			end
			res.push_back(one);
			return;
		end

		while (res.size() < MAX_RESULTS && heap_fill > 0 &&
				heap_slot[1].due < rq.time_value) begin
			one.status        = ST_FIRED;
			one.fired_handler = heap_slot[1].handler;
			one.fired_target  = heap_slot[1].target;
			one.fired_word    = heap_slot[1].word;
			one.fired_ref     = heap_slot[1].ref_tag;
			one.last          = 1'b0;
			res.push_back(one);
			tail = heap_slot[heap_fill];
			heap_fill--;
			pos  = 1;
			done = 1'b0;
			while (!done) begin
				kid = 0;
				key = tail.due;
				if (2 * pos <= heap_fill && heap_slot[2 * pos].due < key) begin
					kid = 2 * pos;
					key = heap_slot[kid].due;
				end
				if (2 * pos + 1 <= heap_fill && heap_slot[2 * pos + 1].due < key)
					kid = 2 * pos + 1;
				if (kid == 0) begin
					heap_slot[pos] = tail;
					done = 1'b1;
				end else begin
					heap_slot[pos] = heap_slot[kid];
					pos = kid;
				end
			end
		end
		n_fired += res.size();
		if (res.size() == MAX_RESULTS)
			n_max_pop++;
		if (res.size() == 0) begin
			one = RSP_NONE;
			res.push_back(one);
			n_empty++;
		end else begin
			res[res.size() - 1].last = 1'b1;
		end
	endfunction

	// Request driver: idle phase set from request count, random gap with
	// junk payload while valid is low, then hold the request until ready.
	// Valid is left high on return so back-to-back requests never toggle it.
	task automatic issue(input req_t rq, input bit has_exp, input rsp_t exp);
		rsp_t         outs [$];
		logic [127:0] noise;

		if (req_count < 140) begin
			gap_pct   = 17;
			stall_pct = 49;
		end else if (req_count < 280) begin
			gap_pct   = 49;
			stall_pct = 17;
		end else begin
			gap_pct   = 0;
			stall_pct = 0;
		end
		while ($urandom_range(0, 99) < gap_pct) begin
			noise = {$urandom, $urandom, $urandom, $urandom};
			req_ch.valid <= 1'b0;
			req_ch.data  <= noise[$bits(req_t)-1:0];
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= rq;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		req_count++;
		heap_apply(rq, outs);
		if (has_exp)
			awaited.push_back(exp);
		else
			foreach (outs[i])
				awaited.push_back(outs[i]);
	endtask

	// Due times: half in a narrow window so ties and climbs are common, some
	// full range, some near the top. Never the all-ones time (see tail rows).
	function automatic logic [31:0] pick_due();
		logic [31:0] t;

		case ($urandom_range(0, 3))
			0, 1: t = $urandom_range(0, 255);
			2: t = $urandom();
			default: t = 32'hFFFF_FF00 + $urandom_range(0, 254);
		endcase
		if (t == 32'hFFFF_FFFF)
			t = 32'hFFFF_FFFE;
		return t;
	endfunction

	function automatic logic [31:0] pick_now();
		case ($urandom_range(0, 3))
			0, 1: return $urandom_range(0, 300);
			2: return $urandom();
			default: return 32'hFFFF_FF00 + $urandom_range(0, 255);
		endcase
	endfunction

	function automatic req_t rand_req(input logic act, input logic [31:0] t);
		req_t rq;

		rq.action     = act;
		rq.time_value = t;
		rq.handler_id = $urandom;
		rq.target_tag = $urandom;
		rq.word_param = $urandom;
		rq.ref_param  = $urandom;
		return rq;
	endfunction

	task automatic post_rand();
		issue(rand_req(ACT_POST, pick_due()), 1'b0, RSP_ANY);
	endtask

	task automatic tick_at(input logic [31:0] t);
		issue(rand_req(ACT_TICK, t), 1'b0, RSP_ANY);
	endtask

	// Result checker

	function automatic void chk_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;

		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = rsp_ch.data;
			rsp_count++;
			if (awaited.size() == 0) begin
				$error("result with nothing outstanding: status %0d", got.status);
				errors++;
			end else begin
				want = awaited.pop_front();
				chk_field("status", want.status, got.status);
				chk_field("fired_handler", want.fired_handler, got.fired_handler);
				chk_field("fired_target", want.fired_target, got.fired_target);
				chk_field("fired_word", want.fired_word, got.fired_word);
				chk_field("fired_ref", want.fired_ref, got.fired_ref);
				chk_field("last", want.last, got.last);
			end
		end
		rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Main sequence

	initial begin
		bit first;

		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_HEAD; i++)
			issue(script[i].rq, script[i].has_exp, script[i].exp);

		// Random traffic. The first pick fills the heap so full rejects show up
		// early; its tick may also give a maximum-length pop burst.
		first = 1'b1;
		while (req_count < 410) begin
			case (first ? 7 : $urandom_range(0, 9))
				0, 1, 2: post_rand();
				3, 4: tick_at(pick_now());
				5, 6: begin
					repeat ($urandom_range(2, 12))
						post_rand();
					tick_at(pick_now());
				end
				7: begin
					// fill to the brim, bounce a few, then drain all or part
					while (heap_fill < HEAP_DEPTH)
						post_rand();
					repeat ($urandom_range(1, 3))
						post_rand();
					tick_at($urandom_range(0, 1) ? 32'hFFFF_FFFF : pick_now());
				end
				8: begin
					// tick right at, or just past, the earliest due time
					if (heap_fill > 0)
						tick_at(heap_slot[1].due + $urandom_range(0, 1));
					else
						tick_at(pick_now());
				end
				default: tick_at($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
			endcase
			first = 1'b0;
		end

		// Empty the heap so the tail rows see a known state
		while (heap_fill > 0)
			tick_at(32'hFFFF_FFFF);
		for (int i = SCRIPT_HEAD; i < SCRIPT_ROWS; i++)
			issue(script[i].rq, script[i].has_exp, script[i].exp);
		req_ch.valid <= 1'b0;

		while (awaited.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d requests, checked %0d results: %0d events fired, %0d full-heap rejects,",
			req_count, rsp_count, n_fired, n_rejected);
		$display("  %0d ticks with nothing due, %0d ticks popping the %0d-event maximum",
			n_empty, n_max_pop, MAX_RESULTS);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$error("timed out with %0d results outstanding", awaited.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
